// ===== rtl/mrq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrq_pkg
// Shared types and constants of the multilevel ready queue.
// ----------------------------------------------------------------------------
package mrq_pkg;

	localparam int ID_SLOTS  = 64;
	localparam int ID_W      = $clog2(ID_SLOTS);
	localparam int LEVELS    = 7;
	localparam int LVL_W     = 3;
	localparam int LVL_DEPTH = 2 ** LVL_W;

	typedef enum logic [1:0] {
		KIND_ENQ = 2'd0,
		KIND_REM = 2'd1,
		KIND_SEL = 2'd2,
		KIND_NOP = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OUT_OK        = 2'd0,
		OUT_NOT_FOUND = 2'd1,
		OUT_EMPTY     = 2'd2,
		OUT_DUPLICATE = 2'd3
	} outcome_t;

	typedef struct packed {
		kind_t             kind;
		logic [ID_W-1:0]   proc_id;
		logic [LVL_W-1:0]  level;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0] picked_id;
		outcome_t        outcome;
	} rsp_t;

	// control of the next-pointer store
	typedef struct packed {
		logic            we;
		logic [ID_W-1:0] waddr;
		logic [ID_W-1:0] wdata;
		logic            re;
		logic [ID_W-1:0] raddr;
	} link_port_t;

endpackage

// ===== rtl/mrq_link_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrq_link_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mrq_link_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 6,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/mrq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrq_ctrl
// Operation sequencer: per-level head/tail tables, queued flags and the
// list walk for remove over the next-pointer RAM.
// ----------------------------------------------------------------------------
module mrq_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  mrq_pkg::req_t             req,
	output logic                      res_valid,
	output mrq_pkg::rsp_t             res,
	input  logic                      res_take,
	output mrq_pkg::link_port_t       link,
	input  logic [mrq_pkg::ID_W-1:0]  link_rdata
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DISP,
		S_WALK,
		S_FIN
	} state_t;

	state_t                       state_q, state_d;
	mrq_pkg::kind_t               kind_q, kind_d;
	logic [mrq_pkg::ID_W-1:0]     id_q, id_d;
	logic [mrq_pkg::LVL_W-1:0]    lv_q, lv_d;
	logic [mrq_pkg::ID_W-1:0]     cur_q, cur_d;
	logic [mrq_pkg::ID_W-1:0]     prev_q, prev_d;
	logic                         has_prev_q, has_prev_d;
	mrq_pkg::rsp_t                res_q, res_d;

	logic [mrq_pkg::ID_W-1:0]     head_q [mrq_pkg::LVL_DEPTH];
	logic [mrq_pkg::ID_W-1:0]     tail_q [mrq_pkg::LVL_DEPTH];
	logic [mrq_pkg::LVL_DEPTH-1:0] nonempty_q;
	logic [mrq_pkg::ID_SLOTS-1:0] queued_q;

	logic                         head_we, tail_we, ne_we, ne_wd, qd_we, qd_wd;
	logic [mrq_pkg::ID_W-1:0]     head_wd, tail_wd;

	logic [mrq_pkg::LVL_W-1:0]    req_lv, sel_lv, head_addr;
	logic                         sel_hit, at_tail;
	logic [mrq_pkg::ID_W-1:0]     head_rd, tail_rd;

	// out-of-range levels fold onto the nearest valid one
	always_comb begin
		if (req.level == '0) begin
			req_lv = mrq_pkg::LVL_W'(1);
		end else if (req.level > mrq_pkg::LVL_W'(mrq_pkg::LEVELS)) begin
			req_lv = mrq_pkg::LVL_W'(mrq_pkg::LEVELS);
		end else begin
			req_lv = req.level;
		end
	end

	// highest non-empty level, level 1 first
	always_comb begin
		sel_hit = 1'b0;
		sel_lv  = mrq_pkg::LVL_W'(1);
		for (int p = mrq_pkg::LEVELS; p >= 1; p--) begin
			if (nonempty_q[p]) begin
				sel_hit = 1'b1;
				sel_lv  = mrq_pkg::LVL_W'(p);
			end
		end
	end

	assign head_addr = (kind_q == mrq_pkg::KIND_SEL) ? sel_lv : lv_q;
	assign head_rd   = head_q[head_addr];
	assign tail_rd   = tail_q[lv_q];
	assign at_tail   = (cur_q == tail_rd);

	assign req_stall = (state_q != S_IDLE);
	assign res_valid = (state_q == S_FIN);
	assign res       = res_q;

	always_comb begin
		state_d    = state_q;
		kind_d     = kind_q;
		id_d       = id_q;
		lv_d       = lv_q;
		cur_d      = cur_q;
		prev_d     = prev_q;
		has_prev_d = has_prev_q;
		res_d      = res_q;
		head_we    = 1'b0;
		head_wd    = id_q;
		tail_we    = 1'b0;
		tail_wd    = id_q;
		ne_we      = 1'b0;
		ne_wd      = 1'b0;
		qd_we      = 1'b0;
		qd_wd      = 1'b0;
		link       = '0;

		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					kind_d  = req.kind;
					id_d    = req.proc_id;
					lv_d    = req_lv;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				res_d   = '{picked_id: '0, outcome: mrq_pkg::OUT_OK};
				state_d = S_FIN;
				unique case (kind_q)
					mrq_pkg::KIND_ENQ: begin
						if (queued_q[id_q]) begin
							res_d.outcome = mrq_pkg::OUT_DUPLICATE;
						end else begin
							if (!nonempty_q[lv_q]) begin
								head_we = 1'b1;
								ne_we   = 1'b1;
								ne_wd   = 1'b1;
							end else begin
								link.we    = 1'b1;
								link.waddr = tail_rd;
								link.wdata = id_q;
							end
							tail_we = 1'b1;
							qd_we   = 1'b1;
							qd_wd   = 1'b1;
						end
					end
					mrq_pkg::KIND_REM: begin
						if (!nonempty_q[lv_q]) begin
							res_d.outcome = mrq_pkg::OUT_NOT_FOUND;
						end else begin
							link.re    = 1'b1;
							link.raddr = head_rd;
							cur_d      = head_rd;
							has_prev_d = 1'b0;
							state_d    = S_WALK;
						end
					end
					mrq_pkg::KIND_SEL: begin
						if (sel_hit) begin
							res_d.picked_id = head_rd;
						end else begin
							res_d.picked_id = mrq_pkg::ID_W'(1);
							res_d.outcome   = mrq_pkg::OUT_EMPTY;
						end
					end
					default: begin
					end
				endcase
			end
			S_WALK: begin
				// link_rdata holds next_link[cur_q]
				if (cur_q == id_q) begin
					if (!has_prev_q) begin
						if (at_tail) begin
							ne_we = 1'b1;
							ne_wd = 1'b0;
						end else begin
							head_we = 1'b1;
							head_wd = link_rdata;
						end
					end else begin
						link.we    = 1'b1;
						link.waddr = prev_q;
						link.wdata = link_rdata;
						if (at_tail) begin
							tail_we = 1'b1;
							tail_wd = prev_q;
						end
					end
					qd_we   = 1'b1;
					qd_wd   = 1'b0;
					res_d   = '{picked_id: '0, outcome: mrq_pkg::OUT_OK};
					state_d = S_FIN;
				end else if (at_tail) begin
					res_d   = '{picked_id: '0, outcome: mrq_pkg::OUT_NOT_FOUND};
					state_d = S_FIN;
				end else begin
					prev_d     = cur_q;
					has_prev_d = 1'b1;
					cur_d      = link_rdata;
					link.re    = 1'b1;
					link.raddr = link_rdata;
				end
			end
			S_FIN: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			has_prev_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			has_prev_q <= has_prev_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q <= kind_d;
		id_q   <= id_d;
		lv_q   <= lv_d;
		cur_q  <= cur_d;
		prev_q <= prev_d;
		res_q  <= res_d;
		if (head_we) begin
			head_q[lv_q] <= head_wd;
		end
		if (tail_we) begin
			tail_q[lv_q] <= tail_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nonempty_q <= '0;
			queued_q   <= '0;
		end else begin
			if (ne_we) begin
				nonempty_q[lv_q] <= ne_wd;
			end
			if (qd_we) begin
				queued_q[id_q] <= qd_wd;
			end
		end
	end

endmodule

// ===== rtl/multilevel_ready_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_ready_queue
// Seven-level priority ready queue with FIFO order per level, lists linked
// through one next-pointer RAM; enqueue, remove and select-head operations.
// ----------------------------------------------------------------------------
//
// channel  fields                      handshake
// req      kind, proc_id, level        req_valid / req_stall
// rsp      picked_id, outcome          rsp_valid / rsp_stall
//
// Enqueue, select, the unused kind and a remove on an empty level go from
// transfer through the dispatch and finish states to the output register;
// a remove that walks adds one walk step per entry passed before the id or
// the tail is reached (up to 63), one next-pointer RAM read per step.
// The next request can transfer in the cycle after the register is loaded.
// Reset clears the non-empty and queued flags at once; no clearing pass.
// A stalled result waits in the output register while the next request
// is taken; the sequencer holds its result until that register frees up.
module multilevel_ready_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  mrq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output mrq_pkg::rsp_t rsp
);

	mrq_pkg::link_port_t        link;
	logic [mrq_pkg::ID_W-1:0]   link_rdata;
	logic                       res_valid, res_take;
	mrq_pkg::rsp_t              res;
	logic                       rsp_valid_q;
	mrq_pkg::rsp_t              rsp_q;

	mrq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.res_valid  (res_valid),
		.res        (res),
		.res_take   (res_take),
		.link       (link),
		.link_rdata (link_rdata)
	);

	mrq_link_ram #(
		.DEPTH (mrq_pkg::ID_SLOTS),
		.WIDTH (mrq_pkg::ID_W)
	) u_link_ram (
		.clk   (clk),
		.we    (link.we),
		.waddr (link.waddr),
		.wdata (link.wdata),
		.re    (link.re),
		.raddr (link.raddr),
		.rdata (link_rdata)
	);

	assign res_take = res_valid && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/mrq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrq_checker
// Port-level checks of the multilevel ready queue.
// ----------------------------------------------------------------------------
module mrq_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_stall,
	input  mrq_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  mrq_pkg::rsp_t rsp
);

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("rsp changed while stalled");

	// one request in flight at a time
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while busy");

	a_empty_id: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.outcome == mrq_pkg::OUT_EMPTY |->
		rsp.picked_id == mrq_pkg::ID_W'(1))
		else $error("empty select must give id 1");

	a_err_id: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.outcome == mrq_pkg::OUT_NOT_FOUND ||
		rsp.outcome == mrq_pkg::OUT_DUPLICATE) |-> rsp.picked_id == '0)
		else $error("error result carries an id");

endmodule

bind multilevel_ready_queue mrq_checker u_mrq_checker (.*);
